// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tgb_pkg.sv =====
// shared constants, codes and transfer types of the typing gap buffer checker
`default_nettype none
package tgb_pkg;

  localparam int CAP   = 256;
  localparam int PTR_W = $clog2(CAP + 1);
  localparam int IDX_W = $clog2(CAP);
  localparam int POS_W = 9;

  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_LOAD  = 3'd1;
  localparam logic [2:0] REQ_TYPED = 3'd2;
  localparam logic [2:0] REQ_BKSP  = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_UNTYPED = 2'd1;
  localparam logic [1:0] ST_CORRECT = 2'd2;
  localparam logic [1:0] ST_WRONG   = 2'd3;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] symbol;
    logic [7:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       slot_status;
    logic [7:0]       slot_byte;
    logic             ignored;
    logic             matched;
    logic [POS_W-1:0] typed_pos;
    logic [POS_W-1:0] remaining_pos;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic commit;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/tgb_ctrl.sv =====
// controller: input acceptance, execute step and output register handshake
`default_nettype none
`include "assert_macros.svh"
module tgb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output tgb_pkg::ctrl_cmd_t     cmd
);
  import tgb_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, commit;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && (state_r == S_IDLE);
  assign commit    = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  assign cmd.accept = accept;
  assign cmd.commit = commit;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_CLK(a_accept_exec, clk, rst_n, accept |=> (state_r == S_EXEC), "accept without execute")
  `ASSERT_CLK(a_exec_hold, clk, rst_n, ((state_r == S_EXEC) && !commit) |=> (state_r == S_EXEC), "execute left early")
  `ASSERT_CLK(a_commit_out, clk, rst_n, commit |=> out_valid_r, "result lost after commit")

endmodule
`default_nettype wire

// ===== hdl/tgb_dp.sv =====
// datapath: slot memories, pointers, length register and result register
`default_nettype none
`include "assert_macros.svh"
module tgb_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tgb_pkg::ctrl_cmd_t cmd,
  input  wire tgb_pkg::in_item_t  in_item,
  input  wire logic               cfg_we,
  input  wire logic [8:0]         cfg_text_length,
  output tgb_pkg::out_item_t      out_item
);
  import tgb_pkg::*;

  logic [7:0]       byte_mem [CAP];
  logic [1:0]       stat_mem [CAP];
  logic [CAP-1:0]   stat_vld_r, stat_vld_nxt;

  logic [8:0]       text_length_r;
  logic [PTR_W-1:0] typed_ptr_r, typed_ptr_nxt;
  logic [PTR_W-1:0] remain_ptr_r, remain_ptr_nxt;
  logic [PTR_W-1:0] load_count_r, load_count_nxt;
  logic [PTR_W-1:0] load_base_r, load_base_nxt;
  in_item_t         item_r;
  out_item_t        out_r, out_nxt;

  logic [IDX_W-1:0] rd_addr;
  logic [PTR_W-1:0] tp_m1_in;
  logic [7:0]       rd_byte_r;
  logic [1:0]       rd_stat_r;
  logic             rd_vld_r;

  logic [PTR_W-1:0] tp_m1, rp_m1, len, load_pos;
  logic [1:0]       eff_stat;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_byte;
  logic [1:0]       wr_stat;
  logic             clr_all, clr_en;
  logic [IDX_W-1:0] clr_addr;

  assign tp_m1_in = typed_ptr_r - PTR_W'(1);

  always_comb begin
    case (in_item.req_type)
      REQ_TYPED: rd_addr = remain_ptr_r[IDX_W-1:0];
      REQ_BKSP:  rd_addr = tp_m1_in[IDX_W-1:0];
      default:   rd_addr = IDX_W'(in_item.slot);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r    <= in_item;
      rd_byte_r <= byte_mem[rd_addr];
      rd_stat_r <= stat_mem[rd_addr];
      rd_vld_r  <= stat_vld_r[rd_addr];
    end
    if (wr_en && cmd.commit) begin
      byte_mem[wr_addr] <= wr_byte;
      stat_mem[wr_addr] <= wr_stat;
    end
  end

  assign tp_m1    = typed_ptr_r - PTR_W'(1);
  assign rp_m1    = remain_ptr_r - PTR_W'(1);
  assign load_pos = load_base_r + load_count_r;
  assign eff_stat = rd_vld_r ? rd_stat_r : ST_EMPTY;
  assign len      = (text_length_r > 9'(CAP)) ? PTR_W'(CAP) : PTR_W'(text_length_r);

  always_comb begin
    typed_ptr_nxt  = typed_ptr_r;
    remain_ptr_nxt = remain_ptr_r;
    load_count_nxt = load_count_r;
    load_base_nxt  = load_base_r;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_byte        = item_r.symbol;
    wr_stat        = ST_UNTYPED;
    clr_all        = 1'b0;
    clr_en         = 1'b0;
    clr_addr       = '0;
    out_nxt.slot_status = ST_EMPTY;
    out_nxt.slot_byte   = 8'd0;
    out_nxt.ignored     = 1'b0;
    out_nxt.matched     = 1'b0;
    unique case (item_r.req_type)
      REQ_START: begin
        clr_all        = 1'b1;
        typed_ptr_nxt  = '0;
        remain_ptr_nxt = PTR_W'(CAP) - len;
        load_base_nxt  = PTR_W'(CAP) - len;
        load_count_nxt = '0;
      end
      REQ_LOAD: begin
        if (load_base_r >= PTR_W'(CAP) || load_count_r >= PTR_W'(CAP) - load_base_r) begin
          out_nxt.ignored = 1'b1;
        end else begin
          wr_en               = 1'b1;
          wr_addr             = load_pos[IDX_W-1:0];
          load_count_nxt      = load_count_r + PTR_W'(1);
          out_nxt.slot_status = ST_UNTYPED;
          out_nxt.slot_byte   = item_r.symbol;
        end
      end
      REQ_TYPED: begin
        if (typed_ptr_r == remain_ptr_r || typed_ptr_r >= PTR_W'(CAP)) begin
          out_nxt.ignored = 1'b1;
        end else begin
          wr_en             = 1'b1;
          wr_addr           = typed_ptr_r[IDX_W-1:0];
          typed_ptr_nxt     = typed_ptr_r + PTR_W'(1);
          out_nxt.slot_byte = item_r.symbol;
          if (remain_ptr_r < PTR_W'(CAP) && rd_byte_r == item_r.symbol) begin
            wr_stat             = ST_CORRECT;
            clr_en              = 1'b1;
            clr_addr            = remain_ptr_r[IDX_W-1:0];
            remain_ptr_nxt      = remain_ptr_r + PTR_W'(1);
            out_nxt.matched     = 1'b1;
            out_nxt.slot_status = ST_CORRECT;
          end else begin
            wr_stat             = ST_WRONG;
            out_nxt.slot_status = ST_WRONG;
          end
        end
      end
      REQ_BKSP: begin
        if (typed_ptr_r == '0) begin
          out_nxt.ignored = 1'b1;
        end else begin
          typed_ptr_nxt     = tp_m1;
          clr_en            = 1'b1;
          clr_addr          = tp_m1[IDX_W-1:0];
          out_nxt.slot_byte = rd_byte_r;
          if (eff_stat == ST_CORRECT && remain_ptr_r != '0) begin
            remain_ptr_nxt = rp_m1;
            wr_en          = 1'b1;
            wr_addr        = rp_m1[IDX_W-1:0];
            wr_byte        = rd_byte_r;
          end
        end
      end
      REQ_READ: begin
        if (PTR_W'(item_r.slot) < PTR_W'(CAP)) begin
          out_nxt.slot_status = eff_stat;
          out_nxt.slot_byte   = rd_byte_r;
        end
      end
      default: out_nxt.ignored = 1'b1;
    endcase
    out_nxt.typed_pos     = POS_W'(typed_ptr_nxt);
    out_nxt.remaining_pos = POS_W'(remain_ptr_nxt);
  end

  always_comb begin
    stat_vld_nxt = stat_vld_r;
    if (cmd.commit) begin
      if (clr_all) begin
        stat_vld_nxt = '0;
      end else begin
        if (wr_en) begin
          stat_vld_nxt[wr_addr] = 1'b1;
        end
        // the cleared slot wins when both hit the same entry
        if (clr_en) begin
          stat_vld_nxt[clr_addr] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_vld_r    <= '0;
      text_length_r <= 9'd0;
      typed_ptr_r   <= '0;
      remain_ptr_r  <= PTR_W'(CAP);
      load_count_r  <= '0;
      load_base_r   <= PTR_W'(CAP);
    end else begin
      stat_vld_r <= stat_vld_nxt;
      if (cfg_we) begin
        text_length_r <= cfg_text_length;
      end
      if (cmd.commit) begin
        typed_ptr_r  <= typed_ptr_nxt;
        remain_ptr_r <= remain_ptr_nxt;
        load_count_r <= load_count_nxt;
        load_base_r  <= load_base_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

  `ASSERT_CLK(a_gap_order, clk, rst_n, typed_ptr_r <= remain_ptr_r, "typed pointer past remaining pointer")
  `ASSERT_CLK(a_remain_cap, clk, rst_n, remain_ptr_r <= PTR_W'(CAP), "remaining pointer beyond capacity")
  `ASSERT_CLK(a_load_fill, clk, rst_n, (load_base_r < PTR_W'(CAP)) |-> (load_count_r <= PTR_W'(CAP) - load_base_r), "load count beyond target length")

endmodule
`default_nettype wire

// ===== hdl/typing_gap_buffer_checker_top.sv =====
// top level of the typing gap buffer checker
// an accepted item is registered and executed, then committed to the output register
// when that register is free or draining; no new item is taken until the commit
// a waiting result is held in the output register until its transfer completes
// reset: synchronous active-low rst_n clears pointers, length and all slot status at once
`default_nettype none
module typing_gap_buffer_checker_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire tgb_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output tgb_pkg::out_item_t      out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [8:0]         cfg_text_length
);
  import tgb_pkg::*;

  ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  tgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tgb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_item         (in_item),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_text_length (cfg_text_length),
    .out_item        (out_item)
  );

endmodule
`default_nettype wire
